>>> src/calibration_table_interpolator_defines.svh
// Assertion helpers for the interpolator RTL.
`ifndef CALIBRATION_TABLE_INTERPOLATOR_DEFINES_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, off during reset.
`define CTI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define CTI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/cti_pkg.sv
`default_nettype none

package cti_pkg;

  localparam int VoltWidth        = 24;
  localparam int TempWidth        = 24;
  localparam int ProdWidth        = VoltWidth + TempWidth;
  localparam int IndexWidth       = 4;
  localparam int PointsWidth      = 5;
  localparam int MaxPointsDefault = 16;

  localparam logic [TempWidth-1:0] TempMax = {TempWidth{1'b1}};

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_CONVERT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FLAT = 2'd2,
    ST_SAT  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_SEL,
    FSM_RDA,
    FSM_RDB,
    FSM_DIFF,
    FSM_MUL,
    FSM_DIV
  } fsm_state_e;

  typedef struct packed {
    cmd_e                        cmd;
    logic [IndexWidth-1:0]       point_index;
    logic signed [VoltWidth-1:0] sample_voltage;
    logic [TempWidth-1:0]        point_temperature;
  } item_t;

  typedef struct packed {
    logic [TempWidth-1:0] temperature_out;
    status_e              status;
    logic                 extrapolated;
  } result_t;

endpackage

`default_nettype wire

>>> src/cti_ram.sv
`default_nettype none

module cti_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/cti_div.sv
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module cti_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cti_pkg::ProdWidth-1:0]  dividend_i,
  input  logic [cti_pkg::VoltWidth-1:0]  divisor_i,
  output logic                           done_o,
  output logic [cti_pkg::ProdWidth-1:0]  quotient_o
);
  import cti_pkg::*;

  localparam int CntW = $clog2(ProdWidth);
  localparam logic [CntW-1:0] LastStep = CntW'(ProdWidth - 1);

  logic                 active_q;
  logic                 done_q;
  logic [CntW-1:0]      cnt_q;
  logic [VoltWidth-1:0] rem_q;
  logic [VoltWidth-1:0] div_q;
  logic [ProdWidth-1:0] quo_q;

  logic [VoltWidth:0]   trial;
  logic [VoltWidth:0]   diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[ProdWidth-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out of the quotient register as quotient bits enter.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (active_q) begin
      rem_q <= ge ? diff[VoltWidth-1:0] : trial[VoltWidth-1:0];
      quo_q <= {quo_q[ProdWidth-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> src/calibration_table_interpolator.sv
// Load item: the zero result strobes in the cycle after the transfer.
// Convert item: the time taken is set by the table scan (one RAM read per used point)
// and the bit-serial divider with its 48-bit quotient; a flat segment skips the divider,
// and fewer than two points skip the scan. One item at a time.
// Results strobe for one cycle and cannot be stalled. Reset is asynchronous and
// active low; it clears points_in_use and control, while the table RAMs keep contents.
`default_nettype none

module calibration_table_interpolator #(
  parameter int MaxPoints = cti_pkg::MaxPointsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  cti_pkg::item_t                  item_i,
  output logic                            result_valid_o,
  output cti_pkg::result_t                result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cti_pkg::PointsWidth-1:0] cfg_data_i
);
  import cti_pkg::*;

`include "calibration_table_interpolator_defines.svh"

  localparam int AddrW = $clog2(MaxPoints);
  localparam int CntW  = $clog2(MaxPoints + 1);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  fsm_state_e state_q, state_d;

  logic [PointsWidth-1:0] points_q;        // points_in_use configuration register
  logic [CntW-1:0]        n_q, n_d;        // clamped point count for this item
  logic [CntW-1:0]        scan_q, scan_d;  // next table entry to read during the scan
  logic [CntW-1:0]        cnt_q, cnt_d;    // points at or below the sample
  logic                   chk_vld_q, chk_vld_d;
  logic                   chk_first_q, chk_first_d;
  logic                   chk_last_q, chk_last_d;
  logic                   extr_q, extr_d;
  logic                   out_valid_q, out_valid_d;
  result_t                out_q, out_d;

  logic signed [VoltWidth-1:0] v_q, v_d;    // sample under conversion
  logic [AddrW-1:0]            k_q, k_d;    // chosen segment
  logic signed [VoltWidth-1:0] v1_q, v1_d;
  logic signed [VoltWidth-1:0] v2_q, v2_d;
  logic [TempWidth-1:0]        t1_q, t1_d;
  logic [TempWidth-1:0]        t2_q, t2_d;
  logic [TempWidth-1:0]        dtm_q, dtm_d;  // |T[k+1] - T[k]|
  logic [VoltWidth-1:0]        dxm_q, dxm_d;  // |v - V[k]|
  logic [VoltWidth-1:0]        dvm_q, dvm_d;  // |V[k+1] - V[k]|
  logic                        neg_q, neg_d;  // sign of the correction term

  // ---------------------------------------------------------------------------
  // Table RAMs: written by load items in idle, read only while converting, so
  // reads and writes never meet on one entry; busy is the interlock.
  // ---------------------------------------------------------------------------
  logic                 accept;
  logic                 idx_ok;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [AddrW-1:0]     ram_raddr;
  logic [VoltWidth-1:0] volt_rd;
  logic [TempWidth-1:0] temp_rd;

  assign accept    = start && !busy;
  assign idx_ok    = 32'(item_i.point_index) < 32'(MaxPoints);
  assign ram_we    = accept && (item_i.cmd == CMD_LOAD) && idx_ok;
  assign ram_waddr = AddrW'(item_i.point_index);

  cti_ram #(
    .Width (VoltWidth),
    .Depth (MaxPoints)
  ) u_volt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_i.sample_voltage),
    .raddr_i (ram_raddr),
    .rdata_o (volt_rd)
  );

  cti_ram #(
    .Width (TempWidth),
    .Depth (MaxPoints)
  ) u_temp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (item_i.point_temperature),
    .raddr_i (ram_raddr),
    .rdata_o (temp_rd)
  );

  // ---------------------------------------------------------------------------
  // Divider: |dt| * |dx| / |dv|, the product registered inside the divider.
  // ---------------------------------------------------------------------------
  logic                 div_start;
  logic                 div_done;
  logic [ProdWidth-1:0] prod;
  logic [ProdWidth-1:0] quo;

  assign div_start = (state_q == FSM_MUL);
  assign prod      = dtm_q * dxm_q;

  cti_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod),
    .divisor_i  (dvm_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]      n_eff;   // points_in_use clamped to the table depth
  logic [CntW-1:0]      k_full;
  logic [AddrW-1:0]     k_sel;
  logic [VoltWidth:0]   dv_w;
  logic [VoltWidth:0]   dx_w;
  logic [TempWidth:0]   dt_w;
  logic [VoltWidth:0]   dv_abs;
  logic [VoltWidth:0]   dx_abs;
  logic [TempWidth:0]   dt_abs;
  logic [ProdWidth:0]   t1_ext;
  logic [ProdWidth:0]   sum_w;
  logic [ProdWidth:0]   quo_ext;

  assign n_eff = (32'(points_q) > 32'(MaxPoints)) ? CntW'(MaxPoints) : CntW'(points_q);

  // Segment is count minus one, held within 0..n-2.
  always_comb begin
    k_full = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
    if (k_full > n_q - CntW'(2)) begin
      k_full = n_q - CntW'(2);
    end
    k_sel = k_full[AddrW-1:0];
  end

  assign dv_w   = {v2_q[VoltWidth-1], v2_q} - {v1_q[VoltWidth-1], v1_q};
  assign dx_w   = {v_q[VoltWidth-1], v_q} - {v1_q[VoltWidth-1], v1_q};
  assign dt_w   = {1'b0, t2_q} - {1'b0, t1_q};
  assign dv_abs = dv_w[VoltWidth] ? (VoltWidth+1)'(0) - dv_w : dv_w;
  assign dx_abs = dx_w[VoltWidth] ? (VoltWidth+1)'(0) - dx_w : dx_w;
  assign dt_abs = dt_w[TempWidth] ? (TempWidth+1)'(0) - dt_w : dt_w;

  assign t1_ext  = (ProdWidth+1)'(t1_q);
  assign quo_ext = {1'b0, quo};
  assign sum_w   = t1_ext + quo_ext;

  // ---------------------------------------------------------------------------
  // Sequencer: next state, RAM address, datapath updates and result
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    scan_d      = scan_q;
    cnt_d       = cnt_q;
    chk_vld_d   = 1'b0;
    chk_first_d = chk_first_q;
    chk_last_d  = chk_last_q;
    extr_d      = extr_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    v_d         = v_q;
    k_d         = k_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    dtm_d       = dtm_q;
    dxm_d       = dxm_q;
    dvm_d       = dvm_q;
    neg_d       = neg_q;
    ram_raddr   = '0;

    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if (item_i.cmd == CMD_LOAD) begin
            // Load: the RAM write (for an index within the table) happens this edge, the result is all zero.
            out_valid_d = 1'b1;
            out_d       = '0;
          end else if (n_eff < CntW'(2)) begin
            out_valid_d           = 1'b1;
            out_d                 = '0;
            out_d.status          = ST_FEW;
          end else begin
            n_d     = n_eff;
            v_d     = item_i.sample_voltage;
            scan_d  = '0;
            cnt_d   = '0;
            extr_d  = 1'b0;
            state_d = FSM_SCAN;
          end
        end
      end

      // Issue one read per used point; check each word the cycle after.
      FSM_SCAN: begin
        ram_raddr = scan_q[AddrW-1:0];
        if (scan_q < n_q) begin
          chk_vld_d   = 1'b1;
          chk_first_d = (scan_q == '0);
          chk_last_d  = (scan_q == n_q - 1'b1);
          scan_d      = scan_q + 1'b1;
        end
        if (chk_vld_q) begin
          if ($signed(volt_rd) <= v_q) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (chk_first_q && (v_q < $signed(volt_rd))) begin
            extr_d = 1'b1;
          end
          if (chk_last_q && (v_q > $signed(volt_rd))) begin
            extr_d = 1'b1;
          end
          if (chk_last_q) begin
            state_d = FSM_SEL;
          end
        end
      end

      FSM_SEL: begin
        ram_raddr = k_sel;
        k_d       = k_sel;
        state_d   = FSM_RDA;
      end

      FSM_RDA: begin
        ram_raddr = k_q + 1'b1;
        v1_d      = volt_rd;
        t1_d      = temp_rd;
        state_d   = FSM_RDB;
      end

      FSM_RDB: begin
        v2_d    = volt_rd;
        t2_d    = temp_rd;
        state_d = FSM_DIFF;
      end

      FSM_DIFF: begin
        if (dv_w == '0) begin
          // Flat segment: hand back the lower point's temperature.
          out_valid_d           = 1'b1;
          out_d.temperature_out = t1_q;
          out_d.status          = ST_FLAT;
          out_d.extrapolated    = extr_q;
          state_d               = FSM_IDLE;
        end else begin
          dvm_d   = dv_abs[VoltWidth-1:0];
          dxm_d   = dx_abs[VoltWidth-1:0];
          dtm_d   = dt_abs[TempWidth-1:0];
          neg_d   = dt_w[TempWidth] ^ dx_w[VoltWidth] ^ dv_w[VoltWidth];
          state_d = FSM_MUL;
        end
      end

      FSM_MUL: begin
        state_d = FSM_DIV;
      end

      FSM_DIV: begin
        if (div_done) begin
          out_valid_d        = 1'b1;
          out_d.extrapolated = extr_q;
          out_d.status       = ST_OK;
          if (neg_q) begin
            // Subtract the correction, clip at zero.
            if (quo_ext > t1_ext) begin
              out_d.temperature_out = '0;
              out_d.status          = ST_SAT;
            end else begin
              out_d.temperature_out = t1_q - quo[TempWidth-1:0];
            end
          end else begin
            // Add the correction, clip at full scale.
            if (sum_w > (ProdWidth+1)'(TempMax)) begin
              out_d.temperature_out = TempMax;
              out_d.status          = ST_SAT;
            end else begin
              out_d.temperature_out = sum_w[TempWidth-1:0];
            end
          end
          state_d = FSM_IDLE;
        end
      end

      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      points_q    <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        points_q <= cfg_data_i;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    scan_q      <= scan_d;
    cnt_q       <= cnt_d;
    chk_first_q <= chk_first_d;
    chk_last_q  <= chk_last_d;
    extr_q      <= extr_d;
    out_q       <= out_d;
    v_q         <= v_d;
    k_q         <= k_d;
    v1_q        <= v1_d;
    v2_q        <= v2_d;
    t1_q        <= t1_d;
    t2_q        <= t2_d;
    dtm_q       <= dtm_d;
    dxm_q       <= dxm_d;
    dvm_q       <= dvm_d;
    neg_q       <= neg_d;
  end

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign busy           = (state_q != FSM_IDLE);
  assign cfg_ready_o    = !busy;
  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CTI_ASSERT_IMP(a_result_only_idle, clk_i, rst_ni, result_valid_o, !busy,
    "result strobe while a conversion is still running")
  `CTI_ASSERT_NXT(a_load_zero_result, clk_i, rst_ni,
    start && !busy && item_i.cmd == CMD_LOAD,
    result_valid_o && result_o.temperature_out == '0 && result_o.status == ST_OK
      && !result_o.extrapolated,
    "load transfer did not give a zero result next cycle")
  `CTI_ASSERT_IMP(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == FSM_DIV,
    "divider finished outside the divide state")
  `CTI_ASSERT_IMP(a_scan_two_points, clk_i, rst_ni, state_q == FSM_SCAN, n_q >= CntW'(2),
    "table scan started with fewer than two points")

endmodule

`default_nettype wire
